@@ rtl/mpdc_pkg.sv @@
// Shared types and constants of the media presentation deadline clock.
package mpdc_pkg;

  localparam int unsigned TickW = 64;
  localparam int unsigned UsW = 32;
  localparam int unsigned ConvW = 45;
  localparam int unsigned PreShift = 6;
  localparam int unsigned RecipShift = 72;
  localparam int unsigned RecipW = 59;

  localparam logic [TickW-1:0] US_PER_SECOND = 64'd1000000;
  localparam logic [RecipShift:0] US_DIV = {{(RecipShift-63){1'b0}},
                                            US_PER_SECOND >> PreShift};
  localparam logic [RecipW-1:0] US_RECIP =
    RecipW'(({1'b1, {RecipShift{1'b0}}} + US_DIV - 1'b1) / US_DIV);
  localparam logic [UsW-1:0] TPS_RESET = UsW'(1000000);

  localparam logic [1:0] KIND_ARM = 2'd0;
  localparam logic [1:0] KIND_AUDIO = 2'd1;
  localparam logic [1:0] KIND_VIDEO = 2'd2;

  localparam logic [1:0] STATUS_OK = 2'd0;
  localparam logic [1:0] STATUS_UNARMED = 2'd1;
  localparam logic [1:0] STATUS_STOPPED = 2'd2;

  localparam logic [1:0] REG_TPS = 2'd0;
  localparam logic [1:0] REG_LEAD = 2'd1;
  localparam logic [1:0] REG_AUDIO = 2'd2;
  localparam logic [1:0] REG_VIDEO = 2'd3;

  typedef struct packed {
    logic             busy;
    logic [ConvW-1:0] lead_cnt;
    logic [ConvW-1:0] audio_ticks;
    logic [ConvW-1:0] video_ticks;
  } conv_t;

endpackage

@@ rtl/mpdc_if.sv @@
// Request and response channel interfaces of the deadline clock.
interface mpdc_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [63:0] cur_tick;
  logic [63:0] extra_ticks;
  logic        stop_requested;

  modport source (output valid, kind, cur_tick, extra_ticks, stop_requested, input ready);
  modport sink (input valid, kind, cur_tick, extra_ticks, stop_requested, output ready);
endinterface

interface mpdc_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [63:0] due_tick;
  logic        reached;
  logic        is_armed;

  modport source (output valid, status, due_tick, reached, is_armed, input ready);
  modport sink (input valid, status, due_tick, reached, is_armed, output ready);
endinterface

@@ rtl/mpdc_conv.sv @@
// Sequential microsecond to tick converter: one multiply, then a reciprocal multiply by 1/10^6.
module mpdc_conv (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [31:0]               tps_i,
  input  logic [31:0]               lead_us_i,
  input  logic [31:0]               audio_us_i,
  input  logic [31:0]               video_us_i,
  output mpdc_pkg::conv_t           conv_o
);
  import mpdc_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MUL = 3'd1;
  localparam logic [2:0] ST_P0 = 3'd2;
  localparam logic [2:0] ST_P1 = 3'd3;
  localparam logic [2:0] ST_P2 = 3'd4;
  localparam logic [2:0] ST_P3 = 3'd5;

  localparam int unsigned XW = TickW - PreShift;
  localparam int unsigned QLo = RecipShift - TickW;

  logic [2:0]       state_q, state_d;
  logic [1:0]       sel_q, sel_d;
  logic [XW-1:0]    x_q, x_d;
  logic [TickW-1:0] acc_q, acc_d;
  logic [ConvW-1:0] lead_q, audio_q, video_q;
  logic [UsW-1:0]   mag;
  logic [31:0]      mul_a, mul_b;
  logic [63:0]      prod;
  logic             store;

  always_comb begin
    case (sel_q)
      2'd0:    mag = lead_us_i;
      2'd1:    mag = audio_us_i[31] ? (~audio_us_i + 32'd1) : audio_us_i;
      default: mag = video_us_i[31] ? (~video_us_i + 32'd1) : video_us_i;
    endcase
  end

  // The product is floored by 64 first, which leaves an exact reciprocal
  // division by 15625 done as four 32-bit partial products.
  always_comb begin
    case (state_q)
      ST_MUL: begin
        mul_a = mag;
        mul_b = tps_i;
      end
      ST_P0: begin
        mul_a = x_q[31:0];
        mul_b = US_RECIP[31:0];
      end
      ST_P1: begin
        mul_a = x_q[31:0];
        mul_b = 32'(US_RECIP[RecipW-1:32]);
      end
      ST_P2: begin
        mul_a = 32'(x_q[XW-1:32]);
        mul_b = US_RECIP[31:0];
      end
      ST_P3: begin
        mul_a = 32'(x_q[XW-1:32]);
        mul_b = 32'(US_RECIP[RecipW-1:32]);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod = 64'(mul_a) * 64'(mul_b);

  always_comb begin
    state_d = state_q;
    sel_d = sel_q;
    x_d = x_q;
    acc_d = acc_q;
    store = 1'b0;
    case (state_q)
      ST_MUL: begin
        x_d = prod[TickW-1:PreShift];
        state_d = ST_P0;
      end
      ST_P0: begin
        acc_d = prod;
        state_d = ST_P1;
      end
      ST_P1: begin
        acc_d = {32'd0, acc_q[63:32]} + prod;
        state_d = ST_P2;
      end
      ST_P2: begin
        acc_d = acc_q + prod;
        state_d = ST_P3;
      end
      ST_P3: begin
        acc_d = {32'd0, acc_q[63:32]} + prod;
        store = 1'b1;
        if (sel_q == 2'd2) begin
          state_d = ST_IDLE;
        end else begin
          sel_d = sel_q + 2'd1;
          state_d = ST_MUL;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
    if (start_i) begin
      state_d = ST_MUL;
      sel_d = 2'd0;
      store = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      sel_q <= 2'd0;
      lead_q <= '0;
      audio_q <= '0;
      video_q <= '0;
    end else begin
      state_q <= state_d;
      sel_q <= sel_d;
      if (store) begin
        case (sel_q)
          2'd0:    lead_q <= acc_d[QLo+ConvW-1:QLo];
          2'd1:    audio_q <= acc_d[QLo+ConvW-1:QLo];
          default: video_q <= acc_d[QLo+ConvW-1:QLo];
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d;
    acc_q <= acc_d;
  end

  assign conv_o.busy = (state_q != ST_IDLE);
  assign conv_o.lead_cnt = lead_q;
  assign conv_o.audio_ticks = audio_q;
  assign conv_o.video_ticks = video_q;

endmodule

@@ rtl/media_presentation_deadline_clock.sv @@
// Top level of the media presentation deadline clock.
// Requests arrive on the req channel as beats of kind, cur_tick, extra_ticks and
// stop_requested; each request gives exactly one response beat on the rsp channel,
// in order. An arm beat fixes the epoch once; audio and video beats return the
// deadline for their stream and whether cur_tick has reached it.
// The datapath is an input register, one stage that reads and updates the epoch
// state, and a stage that adds extra_ticks and compares into the response register.
// One beat is taken every cycle while no conversion runs and the stages can advance.
// Tick conversions of the configuration registers are computed after every APB
// write by a multiply and a reciprocal multiply in 32-bit pieces; while they run
// the request channel holds ready low. Configuration is to be written only while
// idle by the user; the block itself does not enforce it.
// After reset the clock is unarmed, the registers hold their reset values and the
// conversions are already valid, so requests are taken at once.
// When the receiver stalls, the response register holds and the earlier stages
// keep filling, so requests are taken until they are full and ready falls.
module media_presentation_deadline_clock (
  input  logic        clk_i,
  input  logic        rst_ni,
  mpdc_req_if.sink    req,
  mpdc_rsp_if.source  rsp,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import mpdc_pkg::*;

  function automatic logic [TickW-1:0] sat_add(logic [TickW-1:0] a, logic [TickW-1:0] b);
    logic [TickW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[TickW] ? '1 : s[TickW-1:0];
  endfunction

  localparam int unsigned PadW = TickW - ConvW;

  logic [31:0] tps_q, lead_q, audio_q, video_q;
  logic        cfg_we;
  conv_t       conv;

  logic             armed_q;
  logic [TickW-1:0] epoch_q;

  logic             v1_q;
  logic [1:0]       k1_q;
  logic [TickW-1:0] now1_q, ext1_q;
  logic             stop1_q;

  logic             v2_q;
  logic [1:0]       k2_q;
  logic [1:0]       stat2_q;
  logic [TickW-1:0] now2_q, ext2_q, base2_q;
  logic             arm2_q;

  logic             ov_q;
  logic [1:0]       ostat_q;
  logic [TickW-1:0] odl_q;
  logic             oreached_q;
  logic             oarm_q;

  logic             en_out, en2, en1;
  logic [TickW-1:0] lead64, arm_epoch, off_ticks, off_base, base_a, epoch_nxt;
  logic             off_neg, armed_nxt;
  logic [1:0]       stat_a;
  logic [TickW-1:0] dl_b;
  logic             reached_b;

  assign cfg_we = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tps_q <= TPS_RESET;
      lead_q <= '0;
      audio_q <= '0;
      video_q <= '0;
    end else if (cfg_we) begin
      case (paddr[3:2])
        REG_TPS:   tps_q <= pwdata;
        REG_LEAD:  lead_q <= pwdata;
        REG_AUDIO: audio_q <= pwdata;
        REG_VIDEO: video_q <= pwdata;
        default:   tps_q <= pwdata;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_TPS:   prdata = tps_q;
      REG_LEAD:  prdata = lead_q;
      REG_AUDIO: prdata = audio_q;
      REG_VIDEO: prdata = video_q;
      default:   prdata = tps_q;
    endcase
  end

  mpdc_conv u_conv (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cfg_we),
    .tps_i      (tps_q),
    .lead_us_i  (lead_q),
    .audio_us_i (audio_q),
    .video_us_i (video_q),
    .conv_o     (conv)
  );

  assign en_out = !ov_q || rsp.ready;
  assign en2 = !v2_q || en_out;
  assign en1 = !v1_q || en2;
  assign req.ready = en1 && !conv.busy;

  // First stage: epoch state is read and updated here, in request order.
  assign lead64 = {{PadW{1'b0}}, conv.lead_cnt};
  assign arm_epoch = sat_add(now1_q, lead64);
  assign off_neg = (k1_q == KIND_AUDIO) ? audio_q[31] : video_q[31];
  assign off_ticks = {{PadW{1'b0}},
                      (k1_q == KIND_AUDIO) ? conv.audio_ticks : conv.video_ticks};

  always_comb begin
    if (off_neg) begin
      off_base = (off_ticks > epoch_q) ? '0 : epoch_q - off_ticks;
    end else begin
      off_base = sat_add(epoch_q, off_ticks);
    end
  end

  always_comb begin
    armed_nxt = armed_q;
    epoch_nxt = epoch_q;
    stat_a = STATUS_OK;
    base_a = '0;
    case (k1_q)
      KIND_ARM: begin
        armed_nxt = 1'b1;
        if (!armed_q) begin
          epoch_nxt = arm_epoch;
        end
        base_a = epoch_nxt;
      end
      KIND_AUDIO, KIND_VIDEO: begin
        if (stop1_q) begin
          stat_a = STATUS_STOPPED;
        end else if (!armed_q) begin
          stat_a = STATUS_UNARMED;
        end
        base_a = off_base;
      end
      default: begin
        base_a = '0;
      end
    endcase
  end

  // Second stage: extra ticks and the reached compare.
  always_comb begin
    if (stat2_q != STATUS_OK) begin
      dl_b = '0;
    end else begin
      case (k2_q)
        KIND_ARM:               dl_b = base2_q;
        KIND_AUDIO, KIND_VIDEO: dl_b = sat_add(base2_q, ext2_q);
        default:                dl_b = '0;
      endcase
    end
  end

  assign reached_b = (stat2_q == STATUS_OK) && (k2_q == KIND_ARM || k2_q == KIND_AUDIO ||
                     k2_q == KIND_VIDEO) && (now2_q >= dl_b);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      ov_q <= 1'b0;
      armed_q <= 1'b0;
      epoch_q <= '0;
    end else begin
      if (en1) begin
        v1_q <= req.valid && req.ready;
      end
      if (en2) begin
        v2_q <= v1_q;
      end
      if (en_out) begin
        ov_q <= v2_q;
      end
      if (en2 && v1_q) begin
        armed_q <= armed_nxt;
        epoch_q <= epoch_nxt;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      k1_q <= req.kind;
      now1_q <= req.cur_tick;
      ext1_q <= req.extra_ticks;
      stop1_q <= req.stop_requested;
    end
    if (en2) begin
      k2_q <= k1_q;
      stat2_q <= stat_a;
      now2_q <= now1_q;
      ext2_q <= ext1_q;
      base2_q <= base_a;
      arm2_q <= armed_nxt;
    end
    if (en_out) begin
      ostat_q <= stat2_q;
      odl_q <= dl_b;
      oreached_q <= reached_b;
      oarm_q <= arm2_q;
    end
  end

  assign rsp.valid = ov_q;
  assign rsp.status = ostat_q;
  assign rsp.due_tick = odl_q;
  assign rsp.reached = oreached_q;
  assign rsp.is_armed = oarm_q;

  a_armed_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    armed_q |=> armed_q)
    else $error("armed flag cleared after arming");

  a_epoch_frozen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    armed_q |=> $stable(epoch_q))
    else $error("epoch changed after arming");

  a_busy_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    conv.busy |-> !req.ready)
    else $error("request taken while conversions are updating");

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp.valid && rsp.status != STATUS_OK) |-> (rsp.due_tick == '0 && !rsp.reached))
    else $error("failed response carries a deadline");

  a_unarmed_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp.valid && !rsp.is_armed) |-> (rsp.due_tick == '0))
    else $error("deadline reported before arming");

endmodule

@@ test/tb_top.sv @@
// Self-checking testbench for the media presentation deadline clock.
`timescale 1ns / 1ps

module tb_top;
  import mpdc_pkg::*;

  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam int unsigned PhaseCount = 8;
  localparam int unsigned BeatsPerPhase = 216;

  typedef struct packed {
    logic [1:0]  kind;
    logic [63:0] cur_tick;
    logic [63:0] extra_ticks;
    logic        stop;
  } req_beat_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [63:0] due_tick;
    logic        reached;
    logic        is_armed;
  } rsp_beat_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  mpdc_req_if req_ch ();
  mpdc_rsp_if rsp_ch ();

  media_presentation_deadline_clock dut (
    .clk_i,
    .rst_ni,
    .req(req_ch),
    .rsp(rsp_ch),
    .psel,
    .penable,
    .pwrite,
    .paddr,
    .pwdata,
    .prdata,
    .pready
  );

  always #10 clk_i = ~clk_i;

  // Register copies and clock state of the deadline predictor.
  logic [31:0] cfg_tps = TPS_RESET;
  logic [31:0] cfg_lead = '0;
  logic [31:0] cfg_audio = '0;
  logic [31:0] cfg_video = '0;
  logic        clock_armed = 1'b0;
  logic [63:0] model_epoch = '0;

  req_beat_t pending_req[$];
  rsp_beat_t expected_rsp[$];

  int send_idle_pct = 24;
  int recv_idle_pct = 64;
  int mismatch_count = 0;
  int settings_written = 0;
  int kind_count[4] = '{default: 0};
  int status_count[4] = '{default: 0};
  int reached_count = 0;

  function automatic logic [63:0] sat_sum(logic [63:0] a, logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[64] ? '1 : s[63:0];
  endfunction

  function automatic logic [63:0] us_to_tick_count(logic [63:0] us);
    return (us * {32'd0, cfg_tps}) / 64'd1000000;
  endfunction

  function automatic logic [63:0] stream_deadline(logic [31:0] off_raw,
                                                  logic [63:0] extra);
    logic [63:0] shift;
    logic [63:0] base;
    if (off_raw[31]) begin
      shift = us_to_tick_count(64'h1_0000_0000 - {32'd0, off_raw});
      base = shift > model_epoch ? '0 : model_epoch - shift;
    end else begin
      base = sat_sum(model_epoch, us_to_tick_count({32'd0, off_raw}));
    end
    return sat_sum(base, extra);
  endfunction

  function automatic rsp_beat_t predict_response(req_beat_t b);
    rsp_beat_t r;
    r = '0;
    r.status = STATUS_OK;
    case (b.kind)
      KIND_ARM: begin
        if (!clock_armed) begin
          model_epoch = sat_sum(b.cur_tick, us_to_tick_count({32'd0, cfg_lead}));
          clock_armed = 1'b1;
        end
        r.due_tick = model_epoch;
        r.reached = b.cur_tick >= model_epoch;
      end
      KIND_AUDIO, KIND_VIDEO: begin
        if (b.stop) begin
          r.status = STATUS_STOPPED;
        end else if (!clock_armed) begin
          r.status = STATUS_UNARMED;
        end else begin
          r.due_tick = stream_deadline(b.kind == KIND_AUDIO ? cfg_audio : cfg_video,
                                       b.extra_ticks);
          r.reached = b.cur_tick >= r.due_tick;
        end
      end
      default: ;
    endcase
    r.is_armed = clock_armed;
    return r;
  endfunction

  function automatic logic [31:0] rand_offset();
    case ($urandom_range(3))
      0: return $urandom;
      1: return $urandom_range(2000000);
      2: return -$urandom_range(2000000);
      default: return $urandom_range(1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
    endcase
  endfunction

  // Half of the cur_tick values land on or next to the deadline so reached toggles.
  function automatic req_beat_t rand_item();
    req_beat_t b;
    logic [63:0] aim;
    int pick;
    pick = $urandom_range(99);
    b.kind = pick < 8 ? KIND_ARM : pick < 12 ? KIND_UNUSED : pick < 56 ? KIND_AUDIO : KIND_VIDEO;
    b.stop = $urandom_range(99) < 12;
    case ($urandom_range(9))
      0, 1, 2, 3, 4: b.extra_ticks = 64'($urandom_range(1000));
      5: b.extra_ticks = '0;
      6: b.extra_ticks = '1;
      7: b.extra_ticks = {$urandom, $urandom};
      default: b.extra_ticks = {24'd0, 8'($urandom), $urandom};
    endcase
    aim = b.kind == KIND_ARM ? model_epoch :
          stream_deadline(b.kind == KIND_VIDEO ? cfg_video : cfg_audio, b.extra_ticks);
    case ($urandom_range(5))
      0, 1: b.cur_tick = aim + 64'($urandom_range(6)) - 64'd3;
      2: b.cur_tick = aim;
      3: b.cur_tick = {$urandom, $urandom};
      4: b.cur_tick = '1;
      default: b.cur_tick = '0;
    endcase
    return b;
  endfunction

  task automatic push_req(logic [1:0] kind, logic [63:0] cur, logic [63:0] extra,
                          logic stop);
    pending_req.push_back('{kind, cur, extra, stop});
  endtask

  task automatic apb_write(logic [1:0] index, logic [31:0] value);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {index, 2'b00};
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (index)
      REG_TPS: cfg_tps = value;
      REG_LEAD: cfg_lead = value;
      REG_AUDIO: cfg_audio = value;
      default: cfg_video = value;
    endcase
    settings_written++;
  endtask

  task automatic wait_idle();
    do @(negedge clk_i);
    while (pending_req.size() != 0 || expected_rsp.size() != 0 || req_ch.valid);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    req_beat_t nxt;
    if (!rst_ni) begin
      req_ch.valid <= 1'b0;
      req_ch.kind <= '0;
      req_ch.cur_tick <= '0;
      req_ch.extra_ticks <= '0;
      req_ch.stop_requested <= 1'b0;
    end else begin
      if (req_ch.valid && req_ch.ready) begin
        expected_rsp.push_back(predict_response({req_ch.kind, req_ch.cur_tick,
                                                 req_ch.extra_ticks, req_ch.stop_requested}));
        kind_count[req_ch.kind]++;
      end
      if (!req_ch.valid || req_ch.ready) begin
        if (pending_req.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = pending_req.pop_front();
          req_ch.valid <= 1'b1;
          req_ch.kind <= nxt.kind;
          req_ch.cur_tick <= nxt.cur_tick;
          req_ch.extra_ticks <= nxt.extra_ticks;
          req_ch.stop_requested <= nxt.stop;
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    rsp_beat_t want;
    if (!rst_ni) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (expected_rsp.size() == 0) begin
          $error("response beat with no request outstanding");
          mismatch_count++;
        end else begin
          want = expected_rsp.pop_front();
          if (rsp_ch.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, rsp_ch.status);
            mismatch_count++;
          end
          if (rsp_ch.due_tick !== want.due_tick) begin
            $error("due_tick: expected %0h, actual %0h", want.due_tick,
                   rsp_ch.due_tick);
            mismatch_count++;
          end
          if (rsp_ch.reached !== want.reached) begin
            $error("reached: expected %0b, actual %0b", want.reached, rsp_ch.reached);
            mismatch_count++;
          end
          if (rsp_ch.is_armed !== want.is_armed) begin
            $error("is_armed: expected %0b, actual %0b", want.is_armed, rsp_ch.is_armed);
            mismatch_count++;
          end
          status_count[want.status]++;
          if (want.reached) reached_count++;
        end
      end
      rsp_ch.ready <= $urandom_range(99) >= recv_idle_pct;
    end
  end

  initial begin
    int ph;
    int n;
    logic [31:0] tps;
    rst_ni = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Queries before arming, stop taking precedence, and the unused kind.
    push_req(KIND_AUDIO, '0, '0, 1'b0);
    push_req(KIND_VIDEO, '1, '1, 1'b0);
    push_req(KIND_AUDIO, 64'd5, 64'd7, 1'b1);
    push_req(KIND_UNUSED, '1, '1, 1'b1);
    wait_idle();

    // The epoch is fixed once per run, either saturated or small.
    if ($urandom_range(1)) begin
      apb_write(REG_TPS, '1);
      apb_write(REG_LEAD, '1);
      push_req(KIND_ARM, 64'hFFFF_FFFF_FFFF_FFF0, '0, 1'b0);
    end else begin
      apb_write(REG_LEAD, $urandom_range(1000000, 1));
      push_req(KIND_ARM, 64'($urandom_range(1048575)), '0, 1'b0);
    end
    push_req(KIND_ARM, '0, '1, 1'b1);
    push_req(KIND_ARM, '1, '0, 1'b0);
    push_req(KIND_AUDIO, '0, '0, 1'b1);
    push_req(KIND_VIDEO, '1, '0, 1'b0);
    push_req(KIND_AUDIO, '0, '1, 1'b0);
    push_req(KIND_UNUSED, '0, '0, 1'b0);
    wait_idle();

    apb_write(REG_AUDIO, 32'h8000_0000);
    apb_write(REG_VIDEO, 32'h7FFF_FFFF);
    push_req(KIND_AUDIO, '0, '0, 1'b0);
    push_req(KIND_VIDEO, '1, '0, 1'b0);
    push_req(KIND_AUDIO, '1, '1, 1'b0);
    push_req(KIND_VIDEO, '0, 64'd1, 1'b0);
    wait_idle();

    for (ph = 0; ph < PhaseCount; ph++) begin
      case (ph)
        0: tps = TPS_RESET;
        1: tps = '1;
        2: tps = 32'd1;
        3: tps = '0;
        4: tps = 32'd3;
        default: tps = $urandom;
      endcase
      apb_write(REG_TPS, tps);
      apb_write(REG_LEAD, ph[0] ? '1 : $urandom);
      if (ph == 1) begin
        apb_write(REG_AUDIO, 32'h8000_0000);
        apb_write(REG_VIDEO, 32'h7FFF_FFFF);
      end else if (ph == 4) begin
        apb_write(REG_AUDIO, 32'hFFFF_FFFF);
        apb_write(REG_VIDEO, 32'd1);
      end else begin
        apb_write(REG_AUDIO, rand_offset());
        apb_write(REG_VIDEO, rand_offset());
      end
      send_idle_pct = ph < 3 ? 24 : ph < 6 ? 64 : 0;
      recv_idle_pct = ph < 3 ? 64 : ph < 6 ? 24 : 0;
      for (n = 0; n < BeatsPerPhase; n++) begin
        pending_req.push_back(rand_item());
        // The sender holds off here until every outstanding response is back.
        if (ph == 2 && n == BeatsPerPhase / 2) wait_idle();
      end
      wait_idle();
    end

    repeat (8) @(posedge clk_i);
    $display("Sent %0d arm, %0d audio, %0d video and %0d unused-kind beats over %0d writes.",
             kind_count[KIND_ARM], kind_count[KIND_AUDIO], kind_count[KIND_VIDEO],
             kind_count[KIND_UNUSED], settings_written);
    $display("Checked %0d ok, %0d unarmed, %0d stopped responses, %0d with deadline reached.",
             status_count[STATUS_OK], status_count[STATUS_UNARMED],
             status_count[STATUS_STOPPED], reached_count);
    if (mismatch_count == 0 && expected_rsp.size() == 0) begin
      $display("media_presentation_deadline_clock regression: pass");
    end else begin
      $display("media_presentation_deadline_clock regression: fail");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("media_presentation_deadline_clock regression: fail");
    $finish;
  end

endmodule
